// ===== design/button_click_gesture_detector_macros.svh =====
// ----------------------------------------------------------------------------
// Button gesture detector assertion macros
// Shared assertion forms for the gesture detector, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_GESTURE_DETECTOR_MACROS_SVH
`define BUTTON_CLICK_GESTURE_DETECTOR_MACROS_SVH

// same-cycle implication
`define BCGD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BCGD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bcgd_pkg.sv =====
// ----------------------------------------------------------------------------
// Button gesture detector package
// Event codes, queued-event codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package bcgd_pkg;

  typedef enum logic [2:0] {
    EVT_PRESSED  = 3'd0,
    EVT_RELEASED = 3'd1,
    EVT_CLICK    = 3'd2,
    EVT_DOUBLE   = 3'd3,
    EVT_HOLD     = 3'd4
  } evt_code_t;

  typedef enum logic [1:0] {
    QUE_NONE   = 2'd0,
    QUE_CLICK  = 2'd1,
    QUE_DOUBLE = 2'd2
  } que_code_t;

  typedef enum logic [1:0] {
    CFG_DC_INTERVAL = 2'd0,
    CFG_HOLD_THRESH = 2'd1,
    CFG_DC_ENABLE   = 2'd2
  } cfg_idx_t;

  localparam int TIME_W  = 32;
  localparam int CNT_W   = 16;
  localparam int CFG_W   = 16;

  localparam logic [CFG_W-1:0] DC_INTERVAL_RST = 16'd500;
  localparam logic [CFG_W-1:0] HOLD_THRESH_RST = 16'd750;

endpackage

// ===== design/button_click_gesture_detector.sv =====
// One poll per beat: timestamp and button level in, at most one gesture
// event out. Each accepted poll is decoded combinationally and its event,
// if any, sits in the output register from the next cycle on; the block
// sustains one poll per clock and takes a new beat whenever the output
// register is empty or is being drained in the same cycle. Polls that give
// no event still update the detector state and leave the output untouched.
// ----------------------------------------------------------------------------
// Button click / double click / hold detector
// Tracks press timing and flags per poll and emits pressed, released, click,
// double click or click-and-hold events with the running press count.
// ----------------------------------------------------------------------------
`include "button_click_gesture_detector_macros.svh"

module button_click_gesture_detector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] now_ms, [32] button_level, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [2:0] event_code, [18:3] press_count, rest zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  logic [bcgd_pkg::CFG_W-1:0]  dc_interval_r;
  logic [bcgd_pkg::CFG_W-1:0]  hold_thresh_r;
  logic                        dc_enable_r;

  logic [bcgd_pkg::TIME_W-1:0] last_press_r, last_press_nxt;
  logic                        is_pressed_r, is_pressed_nxt;
  logic                        in_dc_r, in_dc_nxt;
  logic                        click_pend_r, click_pend_nxt;
  logic [bcgd_pkg::CNT_W-1:0]  press_cnt_r, press_cnt_nxt;
  bcgd_pkg::que_code_t         queue_r, queue_nxt;

  logic                        out_valid_r;
  bcgd_pkg::evt_code_t         out_code_r;
  logic [bcgd_pkg::CNT_W-1:0]  out_cnt_r;

  logic [bcgd_pkg::TIME_W-1:0] now_ms;
  logic                        level;
  logic [bcgd_pkg::TIME_W-1:0] elapsed;
  logic [bcgd_pkg::TIME_W-1:0] interval_ext;
  logic [bcgd_pkg::TIME_W-1:0] hold_ext;
  logic                        dc_on;
  logic                        in_accept;
  logic                        emit;
  bcgd_pkg::evt_code_t         emit_code;

  assign now_ms       = in_tdata[31:0];
  assign level        = in_tdata[32];
  assign elapsed      = now_ms - last_press_r;
  assign interval_ext = {16'd0, dc_interval_r};
  assign hold_ext     = {16'd0, hold_thresh_r};
  assign dc_on        = dc_enable_r && (dc_interval_r != '0);

  assign in_tready  = !out_valid_r || out_tready;
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_cnt_r, out_code_r};

  // per-poll decode
  always_comb begin
    last_press_nxt = last_press_r;
    is_pressed_nxt = is_pressed_r;
    in_dc_nxt      = in_dc_r;
    click_pend_nxt = click_pend_r;
    press_cnt_nxt  = press_cnt_r;
    queue_nxt      = bcgd_pkg::QUE_NONE;
    emit           = 1'b0;
    emit_code      = bcgd_pkg::EVT_PRESSED;
    if (queue_r == bcgd_pkg::QUE_CLICK || queue_r == bcgd_pkg::QUE_DOUBLE) begin
      emit      = 1'b1;
      emit_code = (queue_r == bcgd_pkg::QUE_CLICK) ? bcgd_pkg::EVT_CLICK
                                                   : bcgd_pkg::EVT_DOUBLE;
    end else if (is_pressed_r) begin
      if (level) begin
        if (elapsed > hold_ext) begin
          emit      = 1'b1;
          emit_code = bcgd_pkg::EVT_HOLD;
        end
      end else begin
        is_pressed_nxt = 1'b0;
        emit           = 1'b1;
        emit_code      = bcgd_pkg::EVT_RELEASED;
        if (dc_on) begin
          if (in_dc_r) begin
            in_dc_nxt      = 1'b0;
            click_pend_nxt = 1'b0;
            if (elapsed < interval_ext) begin
              queue_nxt = bcgd_pkg::QUE_DOUBLE;
            end else if (!(elapsed > hold_ext)) begin
              queue_nxt = bcgd_pkg::QUE_CLICK;
            end
          end else if (elapsed > hold_ext) begin
            click_pend_nxt = 1'b0;
          end else if (elapsed > interval_ext) begin
            click_pend_nxt = 1'b0;
            queue_nxt      = bcgd_pkg::QUE_CLICK;
          end else begin
            click_pend_nxt = 1'b1;
          end
        end else begin
          in_dc_nxt = 1'b0;
          if (elapsed < hold_ext) begin
            queue_nxt = bcgd_pkg::QUE_CLICK;
          end
        end
      end
    end else if (level) begin
      if (dc_on && (elapsed < interval_ext)) begin
        in_dc_nxt = 1'b1;
      end else begin
        last_press_nxt = now_ms;
      end
      is_pressed_nxt = 1'b1;
      press_cnt_nxt  = press_cnt_r + 1'b1;
      emit           = 1'b1;
      emit_code      = bcgd_pkg::EVT_PRESSED;
    end else if (click_pend_r && (elapsed > interval_ext)) begin
      in_dc_nxt      = 1'b0;
      click_pend_nxt = 1'b0;
      emit           = 1'b1;
      emit_code      = bcgd_pkg::EVT_CLICK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_interval_r <= bcgd_pkg::DC_INTERVAL_RST;
      hold_thresh_r <= bcgd_pkg::HOLD_THRESH_RST;
      dc_enable_r   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bcgd_pkg::CFG_DC_INTERVAL: dc_interval_r <= cfg_wdata;
        bcgd_pkg::CFG_HOLD_THRESH: hold_thresh_r <= cfg_wdata;
        bcgd_pkg::CFG_DC_ENABLE:   dc_enable_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_press_r <= '0;
      is_pressed_r <= 1'b0;
      in_dc_r      <= 1'b0;
      click_pend_r <= 1'b0;
      press_cnt_r  <= '0;
      queue_r      <= bcgd_pkg::QUE_NONE;
    end else if (in_accept) begin
      last_press_r <= last_press_nxt;
      is_pressed_r <= is_pressed_nxt;
      in_dc_r      <= in_dc_nxt;
      click_pend_r <= click_pend_nxt;
      press_cnt_r  <= press_cnt_nxt;
      queue_r      <= queue_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      out_code_r <= emit_code;
      out_cnt_r  <= press_cnt_nxt;
    end
  end

  `BCGD_ASSERT_NEXT(a_queue_sent, in_accept && (queue_r != bcgd_pkg::QUE_NONE), out_valid_r && (out_code_r == bcgd_pkg::EVT_CLICK || out_code_r == bcgd_pkg::EVT_DOUBLE), "queued event not sent")
  `BCGD_ASSERT_NOW(a_queue_released, queue_r != bcgd_pkg::QUE_NONE, !is_pressed_r, "event queued while pressed")
  `BCGD_ASSERT_NOW(a_dc_pressed, in_dc_r, is_pressed_r, "double click window open while released")
  `BCGD_ASSERT_NEXT(a_count_press, in_accept && (press_cnt_nxt != press_cnt_r), out_valid_r && (out_code_r == bcgd_pkg::EVT_PRESSED), "count moved without press event")

endmodule

// ===== verif/button_click_gesture_detector_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Button gesture detector testbench
// Streams timestamped button polls through the detector, decodes each accepted
// poll in a local gesture model and checks every event beat (code and press
// count) in order. Random gaps and stalls on both sides, register settings
// changed between idle phases, extremes of interval and threshold included.
// ----------------------------------------------------------------------------
module button_click_gesture_detector_test;

  localparam int WATCHDOG_LIMIT = 400;
  localparam int RANDOM_POLLS   = 900;

  typedef struct packed {
    bcgd_pkg::evt_code_t evt;
    logic [15:0]         count;
  } gesture_evt_t;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [39:0]        in_tdata;   // [31:0] now_ms, [32] button_level, rest zero
  logic               out_tvalid;
  logic               out_tready;
  logic [23:0]        out_tdata;  // [2:0] event_code, [18:3] press_count, rest zero
  logic               cfg_we;
  bcgd_pkg::cfg_idx_t cfg_addr;
  logic [15:0]        cfg_wdata;

  // detector model state
  logic [15:0]         dc_interval;
  logic [15:0]         hold_thresh;
  logic                dc_enable;
  logic [31:0]         last_press_ms;
  logic                held;
  logic                in_dbl;
  logic                click_pend;
  logic [15:0]         press_cnt;
  bcgd_pkg::que_code_t queued;

  logic [32:0]  poll_fifo[$];       // {button_level, now_ms}
  gesture_evt_t pending_events[$];
  gesture_evt_t want_evt;

  logic        in_fire;
  logic        out_fire;
  logic        quiet_mode;
  int          send_gap;
  int          recv_stall;
  int          idle_cycles;
  int          polls_queued;
  int          polls_done;
  int          errors;
  int          settings_used;
  int          evt_seen[5];
  logic [31:0] t_now;

  button_click_gesture_detector u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic void decode_poll(logic [31:0] now, logic level);
    logic                dc_on;
    logic [31:0]         elapsed;
    logic                fire;
    bcgd_pkg::evt_code_t code;
    dc_on   = dc_enable && (dc_interval != 16'd0);
    elapsed = now - last_press_ms;
    fire    = 1'b0;
    code    = bcgd_pkg::EVT_PRESSED;
    if (queued == bcgd_pkg::QUE_CLICK || queued == bcgd_pkg::QUE_DOUBLE) begin
      fire   = 1'b1;
      code   = (queued == bcgd_pkg::QUE_CLICK) ? bcgd_pkg::EVT_CLICK : bcgd_pkg::EVT_DOUBLE;
      queued = bcgd_pkg::QUE_NONE;
    end else if (held) begin
      queued = bcgd_pkg::QUE_NONE;
      if (level) begin
        if (elapsed > hold_thresh) begin
          fire = 1'b1;
          code = bcgd_pkg::EVT_HOLD;
        end
      end else begin
        held = 1'b0;
        fire = 1'b1;
        code = bcgd_pkg::EVT_RELEASED;
        if (dc_on) begin
          if (in_dbl) begin
            in_dbl     = 1'b0;
            click_pend = 1'b0;
            if (elapsed < dc_interval)
              queued = bcgd_pkg::QUE_DOUBLE;
            else if (elapsed <= hold_thresh)
              queued = bcgd_pkg::QUE_CLICK;
          end else if (elapsed > hold_thresh) begin
            click_pend = 1'b0;
          end else if (elapsed > dc_interval) begin
            click_pend = 1'b0;
            queued     = bcgd_pkg::QUE_CLICK;
          end else begin
            click_pend = 1'b1;
          end
        end else begin
          in_dbl = 1'b0;
          if (elapsed < hold_thresh)
            queued = bcgd_pkg::QUE_CLICK;
        end
      end
    end else if (level) begin
      queued = bcgd_pkg::QUE_NONE;
      if (dc_on && elapsed < dc_interval)
        in_dbl = 1'b1;
      else
        last_press_ms = now;
      held      = 1'b1;
      press_cnt = press_cnt + 16'd1;
      fire      = 1'b1;
      code      = bcgd_pkg::EVT_PRESSED;
    end else begin
      queued = bcgd_pkg::QUE_NONE;
      if (click_pend && elapsed > dc_interval) begin
        in_dbl     = 1'b0;
        click_pend = 1'b0;
        fire       = 1'b1;
        code       = bcgd_pkg::EVT_CLICK;
      end
    end
    if (fire)
      pending_events.push_back('{evt: code, count: press_cnt});
  endfunction

  function automatic int draw_wait();
    if (quiet_mode || $urandom_range(0, 2) == 0)
      return 0;
    return $urandom_range(0, 16);
  endfunction

  // offsets cluster around the interval and threshold edges
  function automatic logic [31:0] pick_offset();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3);
      1: return dc_interval + $urandom_range(0, 2) - 1;
      2: return hold_thresh + $urandom_range(0, 2) - 1;
      3: return $urandom_range(0, dc_interval);
      4: return $urandom_range(0, hold_thresh + 2);
      default: return $urandom_range(0, dc_interval + hold_thresh + 8);
    endcase
  endfunction

  function automatic logic [15:0] pick_setting();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return $urandom_range(1, 40);
      3: return $urandom_range(0, 2000);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic void poll_at(logic [31:0] now, logic level);
    poll_fifo.push_back({level, now});
    polls_queued++;
    t_now = now;
  endfunction

  task automatic write_reg(bcgd_pkg::cfg_idx_t idx, logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    case (idx)
      bcgd_pkg::CFG_DC_INTERVAL: dc_interval = value;
      bcgd_pkg::CFG_HOLD_THRESH: hold_thresh = value;
      bcgd_pkg::CFG_DC_ENABLE:   dc_enable   = value[0];
      default: ;
    endcase
    settings_used++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (polls_done != polls_queued) @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one press burst; all offsets count from the first press
  task automatic random_gesture();
    logic [31:0] base;
    logic [31:0] t_rel;
    int          presses;
    base    = t_now + pick_offset();
    presses = $urandom_range(1, 3);
    t_rel   = base;
    repeat (presses) begin
      poll_at(base + ((t_rel == base) ? 32'd0 : pick_offset()), 1'b1);
      repeat ($urandom_range(0, 3)) poll_at(base + pick_offset(), 1'b1);
      t_rel = base + pick_offset();
      poll_at(t_rel, 1'b0);
      poll_at(t_rel + $urandom_range(0, 3), 1'($urandom_range(0, 1)));
    end
    repeat ($urandom_range(0, 3)) poll_at(base + pick_offset(), 1'b0);
    t_now = base + pick_offset() + $urandom_range(0, 2000);
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (poll_fifo.size() > 0) begin
        in_tdata  <= {7'd0, poll_fifo.pop_front()};
        in_tvalid <= 1'b1;
        send_gap  = draw_wait();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_fire)
        recv_stall = draw_wait();
      if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    in_fire  = rst_n && in_tvalid && in_tready;
    out_fire = rst_n && out_tvalid && out_tready;
    if (out_fire) begin
      if (pending_events.size() == 0) begin
        $error("event beat with nothing expected: tdata %h", out_tdata);
        errors++;
      end else begin
        want_evt = pending_events.pop_front();
        evt_seen[int'(want_evt.evt)]++;
        if (out_tdata[2:0] !== want_evt.evt) begin
          $error("event_code: expected %0d, actual %0d", want_evt.evt, out_tdata[2:0]);
          errors++;
        end
        if (out_tdata[18:3] !== want_evt.count) begin
          $error("press_count: expected %0d, actual %0d", want_evt.count, out_tdata[18:3]);
          errors++;
        end
      end
    end
    if (in_fire) begin
      decode_poll(in_tdata[31:0], in_tdata[32]);
      polls_done++;
    end
    if (in_fire || out_fire || cfg_we)
      idle_cycles = 0;
    else
      idle_cycles++;
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  initial begin
    int target;
    int phase_end;
    int phase;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = bcgd_pkg::CFG_DC_INTERVAL;
    cfg_wdata     = '0;
    in_fire       = 1'b0;
    out_fire      = 1'b0;
    quiet_mode    = 1'b0;
    send_gap      = 0;
    recv_stall    = 0;
    idle_cycles   = 0;
    polls_queued  = 0;
    polls_done    = 0;
    errors        = 0;
    settings_used = 0;
    evt_seen      = '{default: 0};
    dc_interval   = bcgd_pkg::DC_INTERVAL_RST;
    hold_thresh   = bcgd_pkg::HOLD_THRESH_RST;
    dc_enable     = 1'b1;
    last_press_ms = '0;
    held          = 1'b0;
    in_dbl        = 1'b0;
    click_pend    = 1'b0;
    press_cnt     = '0;
    queued        = bcgd_pkg::QUE_NONE;
    t_now         = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: hold edge, click after window, double click, pending click
    poll_at(32'd0, 1'b0);
    poll_at(32'd1000, 1'b1);
    poll_at(32'd1750, 1'b1);
    poll_at(32'd1751, 1'b1);
    poll_at(32'd1760, 1'b0);
    poll_at(32'd1761, 1'b0);
    poll_at(32'd3000, 1'b1);
    poll_at(32'd3100, 1'b0);
    poll_at(32'd3499, 1'b1);
    poll_at(32'd3600, 1'b0);
    poll_at(32'd3601, 1'b1);
    poll_at(32'd5000, 1'b1);
    poll_at(32'd5100, 1'b0);
    poll_at(32'd5200, 1'b1);
    poll_at(32'd5300, 1'b0);
    poll_at(32'd5301, 1'b0);
    poll_at(32'd7000, 1'b1);
    poll_at(32'd7100, 1'b0);
    wait_idle();
    write_reg(bcgd_pkg::CFG_DC_ENABLE, 16'd0);
    poll_at(32'd7500, 1'b0);
    poll_at(32'd7501, 1'b0);
    poll_at(32'd9000, 1'b1);
    poll_at(32'd9100, 1'b0);
    poll_at(32'd9101, 1'b0);
    poll_at(32'hFFFF_FFFF, 1'b1);
    poll_at(32'd2, 1'b0);
    poll_at(32'd3, 1'b0);

    target = polls_queued + RANDOM_POLLS;
    phase  = 0;
    while (polls_queued < target) begin
      phase++;
      wait_idle();
      case (phase)
        1: begin
          write_reg(bcgd_pkg::CFG_DC_INTERVAL, 16'hFFFF);
          write_reg(bcgd_pkg::CFG_HOLD_THRESH, 16'd0);
          write_reg(bcgd_pkg::CFG_DC_ENABLE, 16'd1);
        end
        2: begin
          write_reg(bcgd_pkg::CFG_DC_INTERVAL, 16'd0);
          write_reg(bcgd_pkg::CFG_HOLD_THRESH, 16'hFFFF);
        end
        3: begin
          write_reg(bcgd_pkg::CFG_DC_INTERVAL, bcgd_pkg::DC_INTERVAL_RST);
          write_reg(bcgd_pkg::CFG_HOLD_THRESH, bcgd_pkg::HOLD_THRESH_RST);
          write_reg(bcgd_pkg::CFG_DC_ENABLE, 16'h0002);
        end
        default: begin
          if ($urandom_range(0, 3) != 0)
            write_reg(bcgd_pkg::CFG_DC_INTERVAL, pick_setting());
          if ($urandom_range(0, 3) != 0)
            write_reg(bcgd_pkg::CFG_HOLD_THRESH, pick_setting());
          write_reg(bcgd_pkg::CFG_DC_ENABLE,
                    ($urandom_range(0, 3) != 0) ? 16'd1 : 16'd0);
        end
      endcase
      quiet_mode = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0)
        t_now = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      phase_end = polls_queued + $urandom_range(60, 100);
      while (polls_queued < phase_end && polls_queued < target) begin
        if ($urandom_range(0, 7) == 0)
          repeat ($urandom_range(1, 4)) poll_at($urandom, 1'($urandom_range(0, 1)));
        else
          random_gesture();
      end
    end
    wait_idle();
    repeat (4) @(posedge clk);

    $display("Checked %0d polls over %0d register writes: %0d pressed, %0d released,",
             polls_done, settings_used, evt_seen[0], evt_seen[1]);
    $display("%0d click, %0d double click and %0d hold events.",
             evt_seen[2], evt_seen[3], evt_seen[4]);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
